### rtl/pls_pkg.sv
// Shared types and constants for the positional list store.
`timescale 1ns / 1ps

package pls_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int WORD_BITS_DEF = 32;
	localparam int ACT_W         = 2;
	localparam int POS_W         = 7;
	localparam int WORD_W        = 32;
	localparam int STAT_W        = 2;
	localparam int COUNT_W       = 7;

	typedef enum logic [ACT_W-1:0] {
		ACT_READ   = 2'd0,
		ACT_WRITE  = 2'd1,
		ACT_INSERT = 2'd2,
		ACT_REMOVE = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK           = 2'd0,
		ST_BAD_POSITION = 2'd1,
		ST_FULL         = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_CAPTURE,
		S_MOVE_RD,
		S_MOVE_WR,
		S_WR_ONE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

### rtl/pls_mem.sv
// Entry memory: one write port, one registered read port.
`timescale 1ns / 1ps

module pls_mem #(
	parameter int DEPTH = pls_pkg::CAPACITY_DEF,
	parameter int WIDTH = pls_pkg::WORD_BITS_DEF,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  pls_pkg::mem_ctl_t    ctl,
	input  logic [ADDR_W-1:0]    waddr,
	input  logic [ADDR_W-1:0]    raddr,
	input  logic [WIDTH-1:0]     wdata,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/pls_seq.sv
// Request sequencer with the shared index stepper for entry moves.
`timescale 1ns / 1ps

module pls_seq #(
	parameter int CAPACITY  = pls_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = pls_pkg::WORD_BITS_DEF,
	localparam int ADDR_W = $clog2(CAPACITY),
	localparam int CNT_W  = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pls_pkg::ACT_W-1:0]     action,
	input  logic [pls_pkg::POS_W-1:0]     position,
	input  logic [WORD_BITS-1:0]          word_st,
	output pls_pkg::mem_ctl_t             mem_ctl,
	output logic [ADDR_W-1:0]             waddr,
	output logic [ADDR_W-1:0]             raddr,
	output logic [WORD_BITS-1:0]          wdata,
	input  logic [WORD_BITS-1:0]          rdata,
	output logic                          fin,
	input  logic                          out_free,
	output logic [WORD_BITS-1:0]          res_word,
	output pls_pkg::status_t              res_status,
	output logic [CNT_W-1:0]              cnt
);

	localparam int CMP_W = ((CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W) + 1;

	pls_pkg::state_t  state_q, state_d;
	pls_pkg::action_t act;
	pls_pkg::status_t stat_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     cnt_m2;
	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] res_q;
	logic [ADDR_W-1:0]    slot_q;
	logic [ADDR_W-1:0]    idx_q;
	logic [ADDR_W-1:0]    end_q;
	logic [ADDR_W-1:0]    nb;
	logic [ADDR_W-1:0]    slot_a;
	logic                 up_q;
	logic                 move_q;
	logic [CMP_W-1:0]     pos_x;
	logic [CMP_W-1:0]     cnt_x;
	logic [CMP_W-1:0]     lim_x;
	logic [CMP_W-1:0]     slot_x;
	logic                 bad;
	logic                 full;
	logic                 acc;

	assign act    = pls_pkg::action_t'(action);
	assign pos_x  = CMP_W'(position);
	assign cnt_x  = CMP_W'(cnt_q);
	assign lim_x  = (act == pls_pkg::ACT_INSERT) ? cnt_x + CMP_W'(1) : cnt_x;
	assign bad    = (pos_x == '0) || (pos_x > lim_x);
	assign full   = (act == pls_pkg::ACT_INSERT) && (cnt_q == CNT_W'(CAPACITY));
	assign slot_x = pos_x - CMP_W'(1);
	assign slot_a = slot_x[ADDR_W-1:0];
	assign cnt_m2 = cnt_q - CNT_W'(2);
	assign nb     = up_q ? idx_q + ADDR_W'(1) : idx_q - ADDR_W'(1);
	assign acc    = (state_q == pls_pkg::S_IDLE) && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pls_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (acc && !bad && !full) begin
				if (act == pls_pkg::ACT_INSERT) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (act == pls_pkg::ACT_REMOVE) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			word_q <= word_st;
			slot_q <= slot_a;
			res_q  <= '0;
			up_q   <= (act == pls_pkg::ACT_REMOVE);
			move_q <= (act == pls_pkg::ACT_REMOVE) && (pos_x < cnt_x);
			if (bad) begin
				stat_q <= pls_pkg::ST_BAD_POSITION;
			end else if (full) begin
				stat_q <= pls_pkg::ST_FULL;
			end else begin
				stat_q <= pls_pkg::ST_OK;
			end
			if (act == pls_pkg::ACT_INSERT) begin
				idx_q <= cnt_q[ADDR_W-1:0];
				end_q <= slot_a + ADDR_W'(1);
			end else begin
				idx_q <= slot_a;
				end_q <= cnt_m2[ADDR_W-1:0];
			end
		end else if (state_q == pls_pkg::S_CAPTURE) begin
			res_q <= rdata;
		end else if (state_q == pls_pkg::S_MOVE_WR) begin
			idx_q <= nb;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_stall      = 1'b1;
		mem_ctl.rd_en = 1'b0;
		mem_ctl.wr_en = 1'b0;
		raddr         = idx_q;
		waddr         = idx_q;
		wdata         = rdata;
		fin           = 1'b0;
		case (state_q)
			pls_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (bad || full) begin
						state_d = pls_pkg::S_DONE;
					end else begin
						case (act)
							pls_pkg::ACT_READ:   state_d = pls_pkg::S_FETCH;
							pls_pkg::ACT_REMOVE: state_d = pls_pkg::S_FETCH;
							pls_pkg::ACT_WRITE:  state_d = pls_pkg::S_WR_ONE;
							pls_pkg::ACT_INSERT: begin
								state_d = (pos_x <= cnt_x) ? pls_pkg::S_MOVE_RD
								                           : pls_pkg::S_WR_ONE;
							end
							default: state_d = pls_pkg::S_IDLE;
						endcase
					end
				end
			end
			pls_pkg::S_FETCH: begin
				mem_ctl.rd_en = 1'b1;
				raddr         = idx_q;
				state_d       = pls_pkg::S_CAPTURE;
			end
			pls_pkg::S_CAPTURE: begin
				state_d = move_q ? pls_pkg::S_MOVE_RD : pls_pkg::S_DONE;
			end
			pls_pkg::S_MOVE_RD: begin
				mem_ctl.rd_en = 1'b1;
				raddr         = nb;
				state_d       = pls_pkg::S_MOVE_WR;
			end
			pls_pkg::S_MOVE_WR: begin
				mem_ctl.wr_en = 1'b1;
				waddr         = idx_q;
				wdata         = rdata;
				if (idx_q == end_q) begin
					state_d = up_q ? pls_pkg::S_DONE : pls_pkg::S_WR_ONE;
				end else begin
					state_d = pls_pkg::S_MOVE_RD;
				end
			end
			pls_pkg::S_WR_ONE: begin
				mem_ctl.wr_en = 1'b1;
				waddr         = slot_q;
				wdata         = word_q;
				state_d       = pls_pkg::S_DONE;
			end
			pls_pkg::S_DONE: begin
				fin = 1'b1;
				if (out_free) begin
					state_d = pls_pkg::S_IDLE;
				end
			end
			default: state_d = pls_pkg::S_IDLE;
		endcase
	end

	assign res_word   = res_q;
	assign res_status = stat_q;
	assign cnt        = cnt_q;

endmodule

### rtl/positional_list_store.sv
// Top level of the positional list store: sequencer, entry memory, result register.
// A rejected request goes straight to the result; overwrite writes its entry, read fetches
// and captures the entry, remove fetches and captures it and then moves the later entries down,
// and insert moves the entries from its position on up and then writes its entry; each move
// is one read and one write of the single-port-pair entry memory. The next request is taken in
// the cycle after the result is loaded into the output register. Reset clears the entry count and the
// control state; memory contents stay undefined until written.
`timescale 1ns / 1ps

module positional_list_store #(
	parameter int CAPACITY  = pls_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = pls_pkg::WORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pls_pkg::ACT_W-1:0]         action,
	input  logic [pls_pkg::POS_W-1:0]         position,
	input  logic signed [pls_pkg::WORD_W-1:0] word_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pls_pkg::WORD_W-1:0] word_out,
	output logic [pls_pkg::STAT_W-1:0]        status,
	output logic [pls_pkg::COUNT_W-1:0]       entry_count
);

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int WX_W   = (WORD_BITS > pls_pkg::WORD_W) ? WORD_BITS : pls_pkg::WORD_W;
	localparam int CX_W   = (CNT_W > pls_pkg::COUNT_W) ? CNT_W : pls_pkg::COUNT_W;

	pls_pkg::mem_ctl_t mem_ctl;
	pls_pkg::status_t  res_status;
	pls_pkg::status_t  status_q;
	logic [ADDR_W-1:0]         waddr;
	logic [ADDR_W-1:0]         raddr;
	logic [WORD_BITS-1:0]      wdata;
	logic [WORD_BITS-1:0]      rdata;
	logic [WORD_BITS-1:0]      word_st;
	logic [WORD_BITS-1:0]      res_word;
	logic [WX_W-1:0]           win_x;
	logic [WX_W-1:0]           wout_x;
	logic [CX_W-1:0]           cnt_x;
	logic [CNT_W-1:0]          cnt;
	logic [CNT_W-1:0]          count_q;
	logic [pls_pkg::WORD_W-1:0] word_out_q;
	logic                      out_valid_q;
	logic                      fin;
	logic                      out_free;
	logic                      load;

	assign win_x   = WX_W'(word_in);
	assign word_st = win_x[WORD_BITS-1:0];

	pls_seq #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.position   (position),
		.word_st    (word_st),
		.mem_ctl    (mem_ctl),
		.waddr      (waddr),
		.raddr      (raddr),
		.wdata      (wdata),
		.rdata      (rdata),
		.fin        (fin),
		.out_free   (out_free),
		.res_word   (res_word),
		.res_status (res_status),
		.cnt        (cnt)
	);

	pls_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (WORD_BITS)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (waddr),
		.raddr (raddr),
		.wdata (wdata),
		.rdata (rdata)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign load     = fin && out_free;
	assign wout_x   = WX_W'(res_word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_out_q <= wout_x[pls_pkg::WORD_W-1:0];
			status_q   <= res_status;
			count_q    <= cnt;
		end
	end

	assign cnt_x       = CX_W'(count_q);
	assign out_valid   = out_valid_q;
	assign word_out    = word_out_q;
	assign status      = status_q;
	assign entry_count = cnt_x[pls_pkg::COUNT_W-1:0];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(cnt))
		else $error("entry count changed while a request was in progress");

	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fin))
		else $error("result raised without a finished request");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == pls_pkg::ST_FULL)) |-> (count_q == CNT_W'(CAPACITY)))
		else $error("full status with a store that is not full");

endmodule
